// ===== rtl/qfp_pkg.sv =====
package qfp_pkg;

  // Width of one stored value
  localparam int unsigned VAL_W = 32;

  // Comparison counter width and its saturation point
  localparam int unsigned CMP_W = 12;
  localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};

  // Default capacity of the element store
  localparam int unsigned MAX_ITEMS_DEF = 16;

endpackage

// ===== rtl/qfp_ram.sv =====
module qfp_ram
  import qfp_pkg::*;
#(
  parameter int unsigned Width = VAL_W,
  parameter int unsigned Depth = MAX_ITEMS_DEF,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/qfp_seq.sv =====
module qfp_seq
  import qfp_pkg::*;
#(
  parameter int unsigned MaxItems = MAX_ITEMS_DEF,
  localparam int unsigned IW = $clog2(MaxItems),
  localparam int unsigned CW = $clog2(MaxItems + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input words
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [VAL_W-1:0] sample_value_i,
  input  logic             final_item_i,
  // result words
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] sorted_value_o,
  output logic             run_end_o,
  output logic [CMP_W-1:0] comparison_total_o,
  output logic             overflowed_o,
  // element store port
  output logic             em_we_o,
  output logic [IW-1:0]    em_waddr_o,
  output logic [VAL_W-1:0] em_wdata_o,
  output logic             em_re_o,
  output logic [IW-1:0]    em_raddr_o,
  input  logic [VAL_W-1:0] em_rdata_i,
  // range stack port
  output logic             sk_we_o,
  output logic [IW-1:0]    sk_waddr_o,
  output logic [2*IW-1:0]  sk_wdata_o,
  output logic             sk_re_o,
  output logic [IW-1:0]    sk_raddr_o,
  input  logic [2*IW-1:0]  sk_rdata_i
);

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_POP   = 4'd2;
  localparam logic [3:0] ST_POPW  = 4'd3;
  localparam logic [3:0] ST_PIV   = 4'd4;
  localparam logic [3:0] ST_ISCAN = 4'd5;
  localparam logic [3:0] ST_JSCAN = 4'd6;
  localparam logic [3:0] ST_SWAP  = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;
  localparam logic [3:0] ST_FIN2  = 4'd9;
  localparam logic [3:0] ST_PUSH2 = 4'd10;
  localparam logic [3:0] ST_ERD   = 4'd11;
  localparam logic [3:0] ST_EOUT  = 4'd12;
  localparam logic [3:0] ST_EWAIT = 4'd13;

  localparam logic [CW-1:0] CAP = CW'(MaxItems);

  logic [3:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    sp_q, sp_d;
  logic [CMP_W-1:0] cmp_q, cmp_d;
  logic             ovf_q, ovf_d;
  logic [IW-1:0]    lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [VAL_W-1:0] pivot_q, pivot_d, ei_q, ei_d, ej_q, ej_d;
  logic             out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [VAL_W-1:0] out_value_q, out_value_d;

  logic [CMP_W-1:0] cmp_inc;
  logic [CW-1:0]    sp_m1, cnt_m1;
  logic [CW-1:0]    j_w, lo_w, hi_w;
  logic             left_ok, right_ok, left_big;
  logic [2*IW-1:0]  left_rng, right_rng, first_rng, second_rng;
  logic             first_ok, second_ok;
  logic             pivot_ge, pivot_lt;

  // saturating comparison count
  assign cmp_inc = (cmp_q == CMP_MAX) ? cmp_q : cmp_q + 1'b1;
  assign sp_m1   = sp_q - 1'b1;
  assign cnt_m1  = cnt_q - 1'b1;

  // split the range around the final pivot position j
  assign j_w       = CW'(j_q);
  assign lo_w      = CW'(lo_q);
  assign hi_w      = CW'(hi_q);
  assign left_ok   = j_w > lo_w + 1'b1;
  assign right_ok  = j_w + 1'b1 < hi_w;
  assign left_big  = (j_q - lo_q) > (hi_q - j_q);
  assign left_rng  = {lo_q, j_q - 1'b1};
  assign right_rng = {j_q + 1'b1, hi_q};
  assign first_rng  = left_big ? left_rng : right_rng;
  assign first_ok   = left_big ? left_ok : right_ok;
  assign second_rng = left_big ? right_rng : left_rng;
  assign second_ok  = left_big ? right_ok : left_ok;

  // shared signed compare against the pivot
  assign pivot_ge = $signed(em_rdata_i) <= $signed(pivot_q);
  assign pivot_lt = !pivot_ge;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sp_d        = sp_q;
    cmp_d       = cmp_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    pivot_d     = pivot_q;
    ei_d        = ei_q;
    ej_d        = ej_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_value_d = out_value_q;
    em_we_o     = 1'b0;
    em_waddr_o  = i_q;
    em_wdata_o  = em_rdata_i;
    em_re_o     = 1'b0;
    em_raddr_o  = i_q;
    sk_we_o     = 1'b0;
    sk_waddr_o  = sp_q[IW-1:0];
    sk_wdata_o  = first_rng;
    sk_re_o     = 1'b0;
    sk_raddr_o  = sp_m1[IW-1:0];

    case (state_q)
      ST_LOAD: begin
        // store the word while room remains, else flag the drop
        if (in_valid_i) begin
          if (cnt_q < CAP) begin
            em_we_o    = 1'b1;
            em_waddr_o = cnt_q[IW-1:0];
            em_wdata_o = sample_value_i;
            cnt_d      = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (final_item_i) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        cmp_d = '0;
        k_d   = '0;
        if (cnt_q > CW'(1)) begin
          sk_we_o    = 1'b1;
          sk_waddr_o = '0;
          sk_wdata_o = {{IW{1'b0}}, cnt_m1[IW-1:0]};
          sp_d       = CW'(1);
          state_d    = ST_POP;
        end else begin
          state_d = ST_ERD;
        end
      end
      ST_POP: begin
        // take the next range off the stack, or finish
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = ST_ERD;
        end else begin
          sk_re_o = 1'b1;
          sp_d    = sp_m1;
          state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        lo_d       = sk_rdata_i[2*IW-1:IW];
        hi_d       = sk_rdata_i[IW-1:0];
        i_d        = sk_rdata_i[2*IW-1:IW];
        j_d        = sk_rdata_i[IW-1:0];
        em_re_o    = 1'b1;
        em_raddr_o = sk_rdata_i[2*IW-1:IW];
        state_d    = ST_PIV;
      end
      ST_PIV: begin
        pivot_d    = em_rdata_i;
        em_re_o    = 1'b1;
        em_raddr_o = i_q;
        state_d    = ST_ISCAN;
      end
      ST_ISCAN: begin
        // advance i over values not above the pivot
        em_re_o = 1'b1;
        if (pivot_ge && (i_q < hi_q)) begin
          i_d        = i_q + 1'b1;
          cmp_d      = cmp_inc;
          em_raddr_o = i_q + 1'b1;
        end else begin
          ei_d       = em_rdata_i;
          em_raddr_o = j_q;
          state_d    = ST_JSCAN;
        end
      end
      ST_JSCAN: begin
        // retreat j over values above the pivot
        if (pivot_lt && (j_q > lo_q)) begin
          j_d        = j_q - 1'b1;
          cmp_d      = cmp_inc;
          em_re_o    = 1'b1;
          em_raddr_o = j_q - 1'b1;
        end else if (i_q < j_q) begin
          cmp_d      = cmp_inc;
          em_we_o    = 1'b1;
          em_waddr_o = i_q;
          em_wdata_o = em_rdata_i;
          state_d    = ST_SWAP;
        end else begin
          ej_d    = em_rdata_i;
          state_d = ST_FIN;
        end
      end
      ST_SWAP: begin
        // second half of the swap, then rescan from i
        em_we_o    = 1'b1;
        em_waddr_o = j_q;
        em_wdata_o = ei_q;
        em_re_o    = 1'b1;
        em_raddr_o = i_q;
        state_d    = ST_ISCAN;
      end
      ST_FIN: begin
        em_we_o    = 1'b1;
        em_waddr_o = lo_q;
        em_wdata_o = ej_q;
        state_d    = ST_FIN2;
      end
      ST_FIN2: begin
        // drop the pivot in place and push the larger side first
        em_we_o    = 1'b1;
        em_waddr_o = j_q;
        em_wdata_o = pivot_q;
        if (first_ok && (sp_q < CAP)) begin
          sk_we_o    = 1'b1;
          sk_wdata_o = first_rng;
          sp_d       = sp_q + 1'b1;
        end
        state_d = ST_PUSH2;
      end
      ST_PUSH2: begin
        if (second_ok && (sp_q < CAP)) begin
          sk_we_o    = 1'b1;
          sk_wdata_o = second_rng;
          sp_d       = sp_q + 1'b1;
        end
        state_d = ST_POP;
      end
      ST_ERD: begin
        em_re_o    = 1'b1;
        em_raddr_o = k_q;
        state_d    = ST_EOUT;
      end
      ST_EOUT: begin
        out_valid_d = 1'b1;
        out_value_d = em_rdata_i;
        out_last_d  = (CW'(k_q) + 1'b1) == cnt_q;
        state_d     = ST_EWAIT;
      end
      ST_EWAIT: begin
        // hold the word until taken, then fetch the next or close the set
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            sp_d    = '0;
            cmp_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            k_d        = k_q + 1'b1;
            em_re_o    = 1'b1;
            em_raddr_o = k_q + 1'b1;
            state_d    = ST_EOUT;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      sp_q        <= '0;
      cmp_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sp_q        <= sp_d;
      cmp_q       <= cmp_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  // working registers and payload
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    pivot_q     <= pivot_d;
    ei_q        <= ei_d;
    ej_q        <= ej_d;
    out_value_q <= out_value_d;
  end

  assign in_stall_o         = state_q != ST_LOAD;
  assign out_valid_o        = out_valid_q;
  assign sorted_value_o     = out_value_q;
  assign run_end_o          = out_last_q;
  assign comparison_total_o = cmp_q;
  assign overflowed_o       = ovf_q;

endmodule

// ===== rtl/quicksort_first_pivot_counting_core.sv =====
// Quicksort core with first-element pivot and comparison counting.
//
// Input channel (in_valid_i / in_stall_o): one signed 32-bit word per
// transfer. Words are stored, one per cycle, until a word with
// final_item_i set; up to MaxItems words are kept, later ones are dropped
// and the set is flagged overflowed. The final word starts the sort, and
// in_stall_o stays high until every sorted word has been taken.
// Output channel (out_valid_o / out_stall_i): the stored words in ascending
// order, run_end_o on the last, each carrying the comparison count of this
// sort (saturating at 4095) and the overflow flag.
// Each partition works through scan steps of i and j and through swaps,
// all through one element store read port and one compare; each output
// word is read from the store only after the previous one has been
// taken.
// A stalled result word holds still. Reset empties the set, clears the
// counter and flag and returns to loading; the stores need no clearing.
module quicksort_first_pivot_counting_core
  import qfp_pkg::*;
#(
  parameter int unsigned MaxItems = MAX_ITEMS_DEF,
  localparam int unsigned IW = $clog2(MaxItems)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [VAL_W-1:0] sample_value_i,
  input  logic             final_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] sorted_value_o,
  output logic             run_end_o,
  output logic [CMP_W-1:0] comparison_total_o,
  output logic             overflowed_o
);

  logic             em_we, em_re, sk_we, sk_re;
  logic [IW-1:0]    em_waddr, em_raddr, sk_waddr, sk_raddr;
  logic [VAL_W-1:0] em_wdata, em_rdata;
  logic [2*IW-1:0]  sk_wdata, sk_rdata;

  // sort sequencer
  qfp_seq #(
    .MaxItems(MaxItems)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_value_i    (sample_value_i),
    .final_item_i      (final_item_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sorted_value_o    (sorted_value_o),
    .run_end_o         (run_end_o),
    .comparison_total_o(comparison_total_o),
    .overflowed_o      (overflowed_o),
    .em_we_o           (em_we),
    .em_waddr_o        (em_waddr),
    .em_wdata_o        (em_wdata),
    .em_re_o           (em_re),
    .em_raddr_o        (em_raddr),
    .em_rdata_i        (em_rdata),
    .sk_we_o           (sk_we),
    .sk_waddr_o        (sk_waddr),
    .sk_wdata_o        (sk_wdata),
    .sk_re_o           (sk_re),
    .sk_raddr_o        (sk_raddr),
    .sk_rdata_i        (sk_rdata)
  );

  // element store
  qfp_ram #(
    .Width(VAL_W),
    .Depth(MaxItems)
  ) u_elem (
    .clk_i  (clk_i),
    .we_i   (em_we),
    .waddr_i(em_waddr),
    .wdata_i(em_wdata),
    .re_i   (em_re),
    .raddr_i(em_raddr),
    .rdata_o(em_rdata)
  );

  // range stack of low/high index pairs
  qfp_ram #(
    .Width(2 * IW),
    .Depth(MaxItems)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (sk_we),
    .waddr_i(sk_waddr),
    .wdata_i(sk_wdata),
    .re_i   (sk_re),
    .raddr_i(sk_raddr),
    .rdata_o(sk_rdata)
  );

`ifndef NO_ASSERTIONS
  // no word is taken in while results are pending
  a_no_load_during_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("input taken while a result word is pending");

  // the last word of a set closes the output run
  a_run_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && run_end_o |=> !out_valid_o && !in_stall_o)
    else $error("output run did not close after its last word");

  // the count and flag hold still while a result word is pending
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o) |-> $stable(comparison_total_o)
      && $stable(overflowed_o))
    else $error("comparison count changed during output");
`endif

endmodule
